// ----- rtl/acps_pkg.sv -----
`timescale 1ns / 1ps
// Shared widths, fixed-point constants, register indexes and stage payload types
// for the arc path point sampler. No dependencies.
package acps_pkg;

   localparam int IDX_W  = 10;
   localparam int STEP_W = 12;
   localparam int LEN_W  = 16;
   localparam int CURV_W = 18;
   localparam int POS_W  = 18;
   localparam int HEAD_W = 24;
   localparam int TRAV_W = 22;
   localparam int MAG_W  = 18;   // |curvature|, up to 2^17
   localparam int AM_W   = 31;   // |alpha| in 2^-16 rad
   localparam int TH_W   = 45;   // |alpha| in Q30 before reduction
   localparam int ANG_W  = 33;   // reduced angle in Q30
   localparam int CD_W   = 34;   // rotator datapath
   localparam int NUM_W  = 33;   // divider numerator magnitude
   localparam int DEN_W  = 22;   // 16 * |curvature|
   localparam int REM_W  = 40;   // partial remainder
   localparam int QUO_W  = 17;   // quotient bits below the overflow check
   localparam int CSR_IDX_W = 2;

   localparam int MOD_STEPS = 12;   // 2*pi multiples 2^11 .. 2^0

   localparam int DEF_MAX_SAMPLES       = 1024;
   localparam int DEF_CORDIC_ITERATIONS = 18;

   localparam logic [TH_W-1:0]  TWO_PI_Q30  = 45'd6746518852;
   localparam logic [ANG_W-1:0] PI_Q30      = 33'd3373259426;
   localparam logic [ANG_W-1:0] HALF_PI_Q30 = 33'd1686629713;
   localparam logic signed [CD_W-1:0] GAIN_Q30 = 34'sd652032874;
   localparam logic signed [CD_W:0]   ONE_Q30  = 35'sd1073741824;
   localparam logic [QUO_W-1:0] POS_LIMIT  = 17'd70000;
   localparam logic [AM_W-1:0]  HEAD_LIMIT = 31'd4194304;

   localparam logic [CSR_IDX_W-1:0] REG_CURVATURE  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_ARC_LENGTH = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_SAMPLE_STEP = 2'd2;
   localparam logic [CSR_IDX_W-1:0] REG_BACKWARD   = 2'd3;

   localparam logic [31:0] ATAN_TABLE [32] = '{
      32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76,
      32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD,
      32'h000FFFFF, 32'h0007FFFF, 32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF,
      32'h00007FFF, 32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
      32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F, 32'h0000003F,
      32'h0000001F, 32'h0000000F, 32'h00000008, 32'h00000004, 32'h00000002,
      32'h00000001, 32'h00000000};

   typedef struct packed {
      logic [TRAV_W-1:0]        travelled;
      logic                     in_range;
      logic                     last;
      logic signed [HEAD_W-1:0] heading;
      logic                     sin_neg;
      logic                     cos_neg;
   } side_type;

   typedef struct packed {
      logic [REM_W-1:0] rem;
      logic [QUO_W-1:0] quo;
      logic             ovf;
      logic             neg;
   } lane_type;

endpackage

// ----- rtl/arc_path_point_sampler_core.sv -----
`timescale 1ns / 1ps
// Arc path point sampler, top level. Instantiates the reduction, rotator and
// divider cells; depends on acps_pkg.
//
// Usage: send a sample index on the req_ channel; one result per request comes
// back on the rsp_ channel in request order: x, y, swept angle, curvature,
// arc length travelled, in-range and last flags. The primitive starts at the
// origin heading along +x.
// Configuration (curvature, arc length, sample step, backward) is written on
// the csr_ channel, index per register; csr_ready is always high. Write it
// only while no request is in flight.
// Pipeline: 2 front stages + 12 angle reduction stages + 2 fold stages
// + CORDIC_ITERATIONS rotator stages + 1 prep stage + 18 divider stages
// + 1 output stage.
// Throughput: one request per cycle; every cell is a pipeline register with
// its own valid bit, so a request enters each cycle the chain moves.
// Stall: when rsp_ready is low the output stage holds its result, and stages
// behind it keep filling empty slots until the chain is full, then req_ready
// drops. Reset clears all valid bits and loads the register defaults
// (curvature 0, length 10240, step 102, forward).
module arc_path_point_sampler_core import acps_pkg::*; #(
   parameter int MAX_SAMPLES       = DEF_MAX_SAMPLES,
   parameter int CORDIC_ITERATIONS = DEF_CORDIC_ITERATIONS
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [IDX_W-1:0]          req_sample_index,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic signed [POS_W-1:0]   rsp_pos_x,
   output logic signed [POS_W-1:0]   rsp_pos_y,
   output logic signed [HEAD_W-1:0]  rsp_heading,
   output logic signed [CURV_W-1:0]  rsp_point_curvature,
   output logic [TRAV_W-1:0]         rsp_travelled,
   output logic                      rsp_in_range,
   output logic                      rsp_last,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_IDX_W-1:0]      csr_index,
   input  logic [CURV_W-1:0]         csr_data
);

   localparam int NI = CORDIC_ITERATIONS;
   localparam int ND = QUO_W + 1;

   // ---------------- configuration registers
   logic signed [CURV_W-1:0] curv_ff;
   logic [LEN_W-1:0]         len_ff;
   logic [STEP_W-1:0]        step_ff;
   logic                     back_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         curv_ff <= '0;
         len_ff  <= LEN_W'(10240);
         step_ff <= STEP_W'(102);
         back_ff <= 1'b0;
      end else if (csr_valid) begin
         unique case (csr_index)
            REG_CURVATURE:   curv_ff <= csr_data;
            REG_ARC_LENGTH:  len_ff  <= csr_data[LEN_W-1:0];
            REG_SAMPLE_STEP: step_ff <= csr_data[STEP_W-1:0];
            REG_BACKWARD:    back_ff <= csr_data[0];
            default:         curv_ff <= curv_ff;
         endcase
      end
   end

   // derived configuration; stable while requests in flight by user rule only
   logic               line, kneg, aneg;
   logic [MAG_W-1:0]   mag;
   logic [DEN_W-1:0]   den;

   assign line = (curv_ff == '0);
   assign kneg = curv_ff[CURV_W-1];
   assign aneg = kneg ^ back_ff;
   assign mag  = kneg ? MAG_W'(-curv_ff) : MAG_W'(curv_ff);
   assign den  = {mag, 4'b0000};

   // ---------------- stage 0: travelled distance and range flags
   logic        s0_valid_ff, s0_ready, s1_ready;
   side_type    s0_side_ff, s0_side_in;
   logic [TRAV_W-1:0] trav;
   logic [23:0] bound, two_s, two_next;

   assign s0_ready  = !s0_valid_ff || s1_ready;
   assign req_ready = s0_ready;
   assign trav      = TRAV_W'(req_sample_index * step_ff);
   assign bound     = 24'({len_ff, 1'b0}) + 24'(step_ff);
   assign two_s     = {1'b0, trav, 1'b0};
   assign two_next  = {(23'(trav) + 23'(step_ff)), 1'b0};

   always_comb begin
      s0_side_in           = '0;
      s0_side_in.travelled = trav;
      s0_side_in.in_range  = (32'(req_sample_index) < MAX_SAMPLES) && (two_s <= bound);
      s0_side_in.last      = s0_side_in.in_range && (two_next > bound);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else if (s0_ready) begin
         s0_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (s0_ready && req_valid) begin
         s0_side_ff <= s0_side_in;
      end
   end

   // ---------------- stage 1: swept angle magnitude and heading
   logic             s1_valid_ff;
   side_type         s1_side_ff, s1_side_in;
   logic [TH_W-1:0]  s1_th_ff, s1_th_in;
   logic [39:0]      prod;
   logic [40:0]      am_sum;
   logic [AM_W-1:0]  am;
   logic signed [HEAD_W-1:0] head_mag;

   assign prod     = 40'(s0_side_ff.travelled) * 40'(mag);
   assign am_sum   = 41'(prod) + 41'd512;
   assign am       = am_sum[40:10];
   assign head_mag = (am > HEAD_LIMIT) ? HEAD_W'(HEAD_LIMIT) : HEAD_W'(am);
   assign s1_th_in = {am, 14'b0};

   always_comb begin
      s1_side_in = s0_side_ff;
      if (line) begin
         s1_side_in.heading = '0;
      end else begin
         s1_side_in.heading = aneg ? -head_mag : head_mag;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_ready) begin
         s1_valid_ff <= s0_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_ready && s0_valid_ff) begin
         s1_side_ff <= s1_side_in;
         s1_th_ff   <= s1_th_in;
      end
   end

   // ---------------- angle reduction modulo 2*pi
   logic            md_valid [MOD_STEPS+1];
   logic            md_ready [MOD_STEPS+1];
   logic [TH_W-1:0] md_th    [MOD_STEPS+1];
   side_type        md_side  [MOD_STEPS+1];

   assign md_valid[0] = s1_valid_ff;
   assign md_th[0]    = s1_th_ff;
   assign md_side[0]  = s1_side_ff;
   assign s1_ready    = !s1_valid_ff || md_ready[0];

   for (genvar g = 0; g < MOD_STEPS; g++) begin : g_mod
      acps_mod_cell #(.SHIFT(MOD_STEPS - 1 - g)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (md_valid[g]),
         .in_ready  (md_ready[g]),
         .in_th     (md_th[g]),
         .in_side   (md_side[g]),
         .out_valid (md_valid[g+1]),
         .out_ready (md_ready[g+1]),
         .out_th    (md_th[g+1]),
         .out_side  (md_side[g+1])
      );
   end

   // ---------------- fold A: drop half a turn
   logic             fa_valid_ff, fa_ready, fb_ready;
   logic [ANG_W-1:0] fa_th_ff, fa_th_in, md_ang;
   side_type         fa_side_ff, fa_side_in;

   assign md_ang   = md_th[MOD_STEPS][ANG_W-1:0];
   assign fa_ready = !fa_valid_ff || fb_ready;
   assign md_ready[MOD_STEPS] = fa_ready;

   always_comb begin
      fa_side_in = md_side[MOD_STEPS];
      fa_th_in   = md_ang;
      if (md_ang > PI_Q30) begin
         fa_th_in           = md_ang - PI_Q30;
         fa_side_in.sin_neg = 1'b1;
         fa_side_in.cos_neg = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fa_valid_ff <= 1'b0;
      end else if (fa_ready) begin
         fa_valid_ff <= md_valid[MOD_STEPS];
      end
   end

   always_ff @(posedge clock) begin
      if (fa_ready && md_valid[MOD_STEPS]) begin
         fa_th_ff   <= fa_th_in;
         fa_side_ff <= fa_side_in;
      end
   end

   // ---------------- fold B: mirror into the first quadrant
   logic             fb_valid_ff;
   logic [ANG_W-1:0] fb_th_ff, fb_th_in;
   side_type         fb_side_ff, fb_side_in;

   always_comb begin
      fb_side_in = fa_side_ff;
      fb_th_in   = fa_th_ff;
      if (fa_th_ff > HALF_PI_Q30) begin
         fb_th_in           = PI_Q30 - fa_th_ff;
         fb_side_in.cos_neg = !fa_side_ff.cos_neg;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fb_valid_ff <= 1'b0;
      end else if (fb_ready) begin
         fb_valid_ff <= fa_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (fb_ready && fa_valid_ff) begin
         fb_th_ff   <= fb_th_in;
         fb_side_ff <= fb_side_in;
      end
   end

   // ---------------- CORDIC rotator chain
   logic                   cd_valid [NI+1];
   logic                   cd_ready [NI+1];
   logic signed [CD_W-1:0] cd_x     [NI+1];
   logic signed [CD_W-1:0] cd_y     [NI+1];
   logic signed [CD_W-1:0] cd_z     [NI+1];
   side_type               cd_side  [NI+1];

   assign cd_valid[0] = fb_valid_ff;
   assign cd_x[0]     = GAIN_Q30;
   assign cd_y[0]     = '0;
   assign cd_z[0]     = CD_W'(fb_th_ff);
   assign cd_side[0]  = fb_side_ff;
   assign fb_ready    = !fb_valid_ff || cd_ready[0];

   for (genvar g = 0; g < NI; g++) begin : g_cordic
      acps_cordic_cell #(.ITER(g)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (cd_valid[g]),
         .in_ready  (cd_ready[g]),
         .in_x      (cd_x[g]),
         .in_y      (cd_y[g]),
         .in_z      (cd_z[g]),
         .in_side   (cd_side[g]),
         .out_valid (cd_valid[g+1]),
         .out_ready (cd_ready[g+1]),
         .out_x     (cd_x[g+1]),
         .out_y     (cd_y[g+1]),
         .out_z     (cd_z[g+1]),
         .out_side  (cd_side[g+1])
      );
   end

   // divider chain links, driven below the prep stage
   logic           dv_valid [ND+1];
   logic           dv_ready [ND+1];
   lane_type [1:0] dv_lane  [ND+1];
   side_type       dv_side  [ND+1];

   // ---------------- prep: signed numerators to magnitude, add half divisor
   logic                 pp_valid_ff, pp_ready;
   lane_type [1:0]       pp_lane_ff, pp_lane_in;
   side_type             pp_side_ff;
   logic signed [CD_W-1:0] sy;
   logic signed [CD_W:0]   cosv, numy;
   logic [NUM_W-1:0]       xmag, ymag;
   logic [REM_W-1:0]       half_den;

   assign sy       = cd_y[NI];
   assign cosv     = cd_side[NI].cos_neg ? -(CD_W+1)'(cd_x[NI]) : (CD_W+1)'(cd_x[NI]);
   assign numy     = ONE_Q30 - cosv;
   assign xmag     = sy[CD_W-1] ? NUM_W'(-sy) : NUM_W'(sy);
   assign ymag     = numy[CD_W] ? NUM_W'(-numy) : NUM_W'(numy);
   assign half_den = REM_W'({mag, 3'b000});
   assign pp_ready = !pp_valid_ff || dv_ready[0];
   assign cd_ready[NI] = pp_ready;

   always_comb begin
      pp_lane_in[0].rem = REM_W'(xmag) + half_den;
      pp_lane_in[0].quo = '0;
      pp_lane_in[0].ovf = 1'b0;
      pp_lane_in[0].neg = sy[CD_W-1] ^ cd_side[NI].sin_neg ^ aneg ^ kneg;
      pp_lane_in[1].rem = REM_W'(ymag) + half_den;
      pp_lane_in[1].quo = '0;
      pp_lane_in[1].ovf = 1'b0;
      pp_lane_in[1].neg = numy[CD_W] ^ kneg;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pp_valid_ff <= 1'b0;
      end else if (pp_ready) begin
         pp_valid_ff <= cd_valid[NI];
      end
   end

   always_ff @(posedge clock) begin
      if (pp_ready && cd_valid[NI]) begin
         pp_lane_ff <= pp_lane_in;
         pp_side_ff <= cd_side[NI];
      end
   end

   // ---------------- divider chain, overflow check first
   assign dv_valid[0] = pp_valid_ff;
   assign dv_lane[0]  = pp_lane_ff;
   assign dv_side[0]  = pp_side_ff;

   for (genvar g = 0; g < ND; g++) begin : g_div
      acps_div_cell #(.BIT(QUO_W - g)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .den       (den),
         .in_valid  (dv_valid[g]),
         .in_ready  (dv_ready[g]),
         .in_lane   (dv_lane[g]),
         .in_side   (dv_side[g]),
         .out_valid (dv_valid[g+1]),
         .out_ready (dv_ready[g+1]),
         .out_lane  (dv_lane[g+1]),
         .out_side  (dv_side[g+1])
      );
   end

   // ---------------- output register: saturate, apply signs, pick line mode
   logic                    oc_valid_ff, oc_ready;
   logic signed [POS_W-1:0] x_ff, y_ff, x_in, y_in, qx, qy, lx;
   side_type                oc_side_ff;
   logic signed [CURV_W-1:0] pc_ff;
   lane_type                lx_lane, ly_lane;

   assign lx_lane  = dv_lane[ND][0];
   assign ly_lane  = dv_lane[ND][1];
   assign oc_ready = !oc_valid_ff || rsp_ready;
   assign dv_ready[ND] = oc_ready;

   assign qx = (lx_lane.ovf || lx_lane.quo > POS_LIMIT) ? POS_W'(POS_LIMIT) : POS_W'(lx_lane.quo);
   assign qy = (ly_lane.ovf || ly_lane.quo > POS_LIMIT) ? POS_W'(POS_LIMIT) : POS_W'(ly_lane.quo);
   assign lx = (dv_side[ND].travelled > TRAV_W'(POS_LIMIT)) ?
               POS_W'(POS_LIMIT) : POS_W'(dv_side[ND].travelled);

   always_comb begin
      if (line) begin
         x_in = back_ff ? -lx : lx;
         y_in = '0;
      end else begin
         x_in = lx_lane.neg ? -qx : qx;
         y_in = ly_lane.neg ? -qy : qy;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         oc_valid_ff <= 1'b0;
      end else if (oc_ready) begin
         oc_valid_ff <= dv_valid[ND];
      end
   end

   always_ff @(posedge clock) begin
      if (oc_ready && dv_valid[ND]) begin
         x_ff       <= x_in;
         y_ff       <= y_in;
         pc_ff      <= curv_ff;
         oc_side_ff <= dv_side[ND];
      end
   end

   assign rsp_valid           = oc_valid_ff;
   assign rsp_pos_x           = x_ff;
   assign rsp_pos_y           = y_ff;
   assign rsp_heading         = oc_side_ff.heading;
   assign rsp_point_curvature = pc_ff;
   assign rsp_travelled       = oc_side_ff.travelled;
   assign rsp_in_range        = oc_side_ff.in_range;
   assign rsp_last            = oc_side_ff.last;

   // ---------------- assertions
   a_last_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |-> rsp_in_range)
      else $error("last flag without in_range");

   a_line_heading: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_point_curvature == '0 |-> rsp_heading == '0 && rsp_pos_y == '0)
      else $error("line result with nonzero heading or y");

   a_reset_empty: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !s0_valid_ff |-> req_ready)
      else $error("request refused with an empty entry stage");

endmodule

// ----- rtl/acps_mod_cell.sv -----
`timescale 1ns / 1ps
// One reduction cell: subtract 2*pi shifted left by SHIFT when it fits.
// Depends on acps_pkg.
module acps_mod_cell import acps_pkg::*; #(
   parameter int SHIFT = 0
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            in_valid,
   output logic            in_ready,
   input  logic [TH_W-1:0] in_th,
   input  side_type        in_side,
   output logic            out_valid,
   input  logic            out_ready,
   output logic [TH_W-1:0] out_th,
   output side_type        out_side
);

   localparam logic [TH_W-1:0] LIM = TWO_PI_Q30 << SHIFT;

   logic            valid_ff;
   logic [TH_W-1:0] th_ff, th_in;
   side_type        side_ff;

   assign in_ready = !valid_ff || out_ready;
   assign th_in = (in_th >= LIM) ? in_th - LIM : in_th;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         th_ff   <= th_in;
         side_ff <= in_side;
      end
   end

   assign out_valid = valid_ff;
   assign out_th    = th_ff;
   assign out_side  = side_ff;

endmodule

// ----- rtl/acps_cordic_cell.sv -----
`timescale 1ns / 1ps
// One rotation-mode CORDIC iteration with a floor shift by ITER.
// Depends on acps_pkg.
module acps_cordic_cell import acps_pkg::*; #(
   parameter int ITER = 0
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  logic signed [CD_W-1:0] in_x,
   input  logic signed [CD_W-1:0] in_y,
   input  logic signed [CD_W-1:0] in_z,
   input  side_type               in_side,
   output logic                   out_valid,
   input  logic                   out_ready,
   output logic signed [CD_W-1:0] out_x,
   output logic signed [CD_W-1:0] out_y,
   output logic signed [CD_W-1:0] out_z,
   output side_type               out_side
);

   localparam logic signed [CD_W-1:0] ATAN = CD_W'(ATAN_TABLE[ITER]);

   logic                   valid_ff;
   logic signed [CD_W-1:0] x_ff, y_ff, z_ff, x_in, y_in, z_in, dx, dy;
   side_type               side_ff;

   assign in_ready = !valid_ff || out_ready;
   assign dx = in_y >>> ITER;
   assign dy = in_x >>> ITER;

   always_comb begin
      if (!in_z[CD_W-1]) begin
         x_in = in_x - dx;
         y_in = in_y + dy;
         z_in = in_z - ATAN;
      end else begin
         x_in = in_x + dx;
         y_in = in_y - dy;
         z_in = in_z + ATAN;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         x_ff    <= x_in;
         y_ff    <= y_in;
         z_ff    <= z_in;
         side_ff <= in_side;
      end
   end

   assign out_valid = valid_ff;
   assign out_x     = x_ff;
   assign out_y     = y_ff;
   assign out_z     = z_ff;
   assign out_side  = side_ff;

endmodule

// ----- rtl/acps_div_cell.sv -----
`timescale 1ns / 1ps
// One restoring-division cell for the x and y lanes; the top cell only checks
// for quotient overflow. Depends on acps_pkg.
module acps_div_cell import acps_pkg::*; #(
   parameter int BIT = 0
) (
   input  logic              clock,
   input  logic              reset,
   input  logic [DEN_W-1:0]  den,
   input  logic              in_valid,
   output logic              in_ready,
   input  lane_type [1:0]    in_lane,
   input  side_type          in_side,
   output logic              out_valid,
   input  logic              out_ready,
   output lane_type [1:0]    out_lane,
   output side_type          out_side
);

   logic           valid_ff;
   lane_type [1:0] lane_ff, lane_in;
   side_type       side_ff;
   logic [REM_W-1:0] shifted;

   assign in_ready = !valid_ff || out_ready;
   assign shifted  = REM_W'(den) << BIT;

   always_comb begin
      lane_in = in_lane;
      for (int l = 0; l < 2; l++) begin
         if (in_lane[l].rem >= shifted) begin
            if (BIT >= QUO_W) begin
               lane_in[l].ovf = 1'b1;
            end else begin
               lane_in[l].rem = in_lane[l].rem - shifted;
               lane_in[l].quo[BIT % QUO_W] = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         lane_ff <= lane_in;
         side_ff <= in_side;
      end
   end

   assign out_valid = valid_ff;
   assign out_lane  = lane_ff;
   assign out_side  = side_ff;

endmodule
